// File: rtl/deq_pkg.sv
// Shared types and constants for the double-ended queue.
package deq_pkg;

    localparam int DEPTH  = 16;
    localparam int WIDTH  = 32;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;

    localparam int REQ_W       = 3;
    localparam int DATA_W      = 32;
    localparam int STAT_W      = 2;
    localparam int COUNT_OUT_W = 5;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_REAR  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_REAR   = 3'd3,
        REQ_PEEK_FRONT = 3'd4,
        REQ_PEEK_REAR  = 3'd5
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    // Result information that travels alongside the RAM read.
    typedef struct packed {
        logic             rd;
        t_status          status;
        logic [CNT_W-1:0] count;
    } t_s1;

endpackage

// File: rtl/double_ended_queue.sv
// A result passes through the stage-one register and then the output register, and
// back-pressure on i_ready can hold it in either before its transaction completes.
// Throughput: one request per cycle unless stage one stalls; each request makes at most
// one access to the single port of the slot RAM; pointer and count update on acceptance.
// Reset clears the front pointer, the element count and the pipeline valid bits;
// slot contents are not cleared and no clearing pass runs.
module double_ended_queue (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [deq_pkg::REQ_W-1:0]        i_req_type,
    input  logic [deq_pkg::DATA_W-1:0]       i_push_data,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [deq_pkg::DATA_W-1:0]       o_out_data,
    output logic [deq_pkg::STAT_W-1:0]       o_status,
    output logic [deq_pkg::COUNT_OUT_W-1:0]  o_count_after
);

    logic                              accept;
    logic                              s1_valid;
    logic                              s1_take;
    deq_pkg::t_s1                      s1;
    logic [deq_pkg::WIDTH-1:0]         rdata;
    logic                              r_out_valid;
    logic [deq_pkg::DATA_W-1:0]        r_out_data;
    logic [deq_pkg::STAT_W-1:0]        r_out_status;
    logic [deq_pkg::COUNT_OUT_W-1:0]   r_out_count;

    assign s1_take = s1_valid & (~r_out_valid | i_ready);
    assign o_ready = ~s1_valid | s1_take;
    assign accept  = i_valid & o_ready;

    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_req_type  (i_req_type),
        .i_push_data (i_push_data),
        .i_s1_take   (s1_take),
        .o_s1_valid  (s1_valid),
        .o_s1        (s1),
        .o_rdata     (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_take) begin
            r_out_data   <= s1.rd ? deq_pkg::DATA_W'(rdata) : '0;
            r_out_status <= s1.status;
            r_out_count  <= deq_pkg::COUNT_OUT_W'(s1.count);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_data    = r_out_data;
    assign o_status      = r_out_status;
    assign o_count_after = r_out_count;

endmodule

// File: rtl/deq_ram.sv
// Generic single-port RAM with registered read data.
module deq_ram #(
    parameter int W = 32,
    parameter int D = 16
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic                         i_re,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_addr,
    input  logic [W-1:0]                 i_wdata,
    output logic [W-1:0]                 o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_q;

endmodule

// File: rtl/deq_ctrl.sv
// Pointer and count control: decodes a request, drives the slot RAM, and
// registers the result information for the following cycle.
module deq_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [deq_pkg::REQ_W-1:0]   i_req_type,
    input  logic [deq_pkg::DATA_W-1:0]  i_push_data,
    input  logic                        i_s1_take,
    output logic                        o_s1_valid,
    output deq_pkg::t_s1                o_s1,
    output logic [deq_pkg::WIDTH-1:0]   o_rdata
);

    logic [deq_pkg::ADDR_W-1:0] r_front, n_front;
    logic [deq_pkg::CNT_W-1:0]  r_count, n_count;
    logic                       r_s1_valid;
    deq_pkg::t_s1               r_s1, n_s1;

    logic                       full, empty;
    logic [deq_pkg::ADDR_W-1:0] front_m1, front_p1, rear_pos, tail_pos;
    logic [deq_pkg::SUM_W-1:0]  rear_sum, tail_sum;
    logic                       ram_we, ram_re;
    logic [deq_pkg::ADDR_W-1:0] ram_addr;
    deq_pkg::t_req              req;

    assign req   = deq_pkg::t_req'(i_req_type);
    assign full  = (r_count == deq_pkg::CNT_W'(deq_pkg::DEPTH));
    assign empty = (r_count == '0);

    // Ring arithmetic that also holds when DEPTH is not a power of two.
    assign front_m1 = (r_front == '0) ? deq_pkg::ADDR_W'(deq_pkg::DEPTH - 1)
                                      : r_front - 1'b1;
    assign front_p1 = (r_front == deq_pkg::ADDR_W'(deq_pkg::DEPTH - 1)) ? '0
                                      : r_front + 1'b1;

    assign rear_sum = deq_pkg::SUM_W'(r_front) + deq_pkg::SUM_W'(r_count);
    assign tail_sum = rear_sum - 1'b1;
    assign rear_pos = (rear_sum >= deq_pkg::SUM_W'(deq_pkg::DEPTH))
                    ? deq_pkg::ADDR_W'(rear_sum - deq_pkg::SUM_W'(deq_pkg::DEPTH))
                    : deq_pkg::ADDR_W'(rear_sum);
    assign tail_pos = (tail_sum >= deq_pkg::SUM_W'(deq_pkg::DEPTH))
                    ? deq_pkg::ADDR_W'(tail_sum - deq_pkg::SUM_W'(deq_pkg::DEPTH))
                    : deq_pkg::ADDR_W'(tail_sum);

    always_comb begin
        n_front     = r_front;
        n_count     = r_count;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_addr    = r_front;
        n_s1.rd     = 1'b0;
        n_s1.status = deq_pkg::STAT_OK;
        unique case (req) inside
            deq_pkg::REQ_PUSH_FRONT: begin
                if (full) begin
                    n_s1.status = deq_pkg::STAT_FULL;
                end else begin
                    ram_we   = 1'b1;
                    ram_addr = front_m1;
                    n_front  = front_m1;
                    n_count  = r_count + 1'b1;
                end
            end
            deq_pkg::REQ_PUSH_REAR: begin
                if (full) begin
                    n_s1.status = deq_pkg::STAT_FULL;
                end else begin
                    ram_we   = 1'b1;
                    ram_addr = rear_pos;
                    n_count  = r_count + 1'b1;
                end
            end
            deq_pkg::REQ_POP_FRONT, deq_pkg::REQ_PEEK_FRONT: begin
                if (empty) begin
                    n_s1.status = deq_pkg::STAT_EMPTY;
                end else begin
                    ram_re   = 1'b1;
                    n_s1.rd  = 1'b1;
                    ram_addr = r_front;
                    if (req == deq_pkg::REQ_POP_FRONT) begin
                        n_front = front_p1;
                        n_count = r_count - 1'b1;
                    end
                end
            end
            deq_pkg::REQ_POP_REAR, deq_pkg::REQ_PEEK_REAR: begin
                if (empty) begin
                    n_s1.status = deq_pkg::STAT_EMPTY;
                end else begin
                    ram_re   = 1'b1;
                    n_s1.rd  = 1'b1;
                    ram_addr = tail_pos;
                    if (req == deq_pkg::REQ_POP_REAR) begin
                        n_count = r_count - 1'b1;
                    end
                end
            end
            default: begin
                // Undefined request codes leave the state alone.
            end
        endcase
        n_s1.count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front    <= '0;
            r_count    <= '0;
            r_s1_valid <= 1'b0;
        end else if (i_accept) begin
            r_front    <= n_front;
            r_count    <= n_count;
            r_s1_valid <= 1'b1;
        end else if (i_s1_take) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1 <= n_s1;
        end
    end

    // At most one access per transaction, so the single port never conflicts.
    // Read data holds while stage one is stalled because no new read issues.
    deq_ram #(
        .W(deq_pkg::WIDTH),
        .D(deq_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_accept & ram_we),
        .i_re    (i_accept & ram_re),
        .i_addr  (ram_addr),
        .i_wdata (deq_pkg::WIDTH'(i_push_data)),
        .o_rdata (o_rdata)
    );

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;

endmodule
